### sv/aabb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb collider table package
// shared constants, codes and the kind permission table
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int SlotCountDefault = 8;
  localparam int KindCount        = 9;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_MARK  = 3'd1,
    OP_PURGE = 3'd2,
    OP_CLEAR = 3'd3,
    OP_CHECK = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    RES_DONE = 2'd0,
    RES_PAIR = 2'd1,
    RES_ADD  = 2'd2,
    RES_FULL = 2'd3
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  // bit b of row a lets kind a collide with kind b
  function automatic logic permitted(input logic [3:0] a, input logic [3:0] b);
    logic [8:0] row;
    row = 9'h000;
    unique case (a)
      4'd0: row = 9'h000;
      4'd1: row = 9'h184;
      4'd2: row = 9'h17A;
      4'd3: row = 9'h004;
      4'd4: row = 9'h104;
      4'd5: row = 9'h184;
      4'd6: row = 9'h104;
      4'd7: row = 9'h062;
      4'd8: row = 9'h076;
      default: row = 9'h000;
    endcase
    if (b > 4'd8) return 1'b0;
    return row[b];
  endfunction

endpackage

### sv/aabb_collider_table_pair_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb collider table pair check core
// slot table in a synchronous memory, pair check walks slot pairs
// ----------------------------------------------------------------------------
// channel  | ports                         | handshake
// input    | in_*                          | start high while busy low
// result   | out_*                         | out_valid, one cycle, no stall
//
// add, mark, purge, clear, unused codes: result in the cycle after the accepting edge.
// check: states load, read, compare, then done; each row is loaded, each
// occupied row below the last is read and compared against every later slot
// through the one read port; tail_arm_r and tail_r delay the final pair when
// it follows a held one.
// reset clears occupancy and marks; results cannot be stalled.
module aabb_collider_table_pair_check_core #(
  parameter int SLOT_COUNT = aabb_pkg::SlotCountDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [2:0]  in_slot_index,
  input  logic signed [15:0] in_left_edge,
  input  logic signed [15:0] in_top_edge,
  input  logic [14:0] in_box_width,
  input  logic [14:0] in_box_height,
  input  logic [3:0]  in_collider_kind,
  input  logic        in_wants_notice,
  output logic        out_valid,
  output logic [1:0]  out_result_code,
  output logic [2:0]  out_first_slot,
  output logic [2:0]  out_second_slot,
  output logic        out_notify_first,
  output logic        out_notify_second,
  output logic [3:0]  out_occupied_count,
  output logic        out_last_result
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        wid;
    logic [14:0]        hgt;
    logic [3:0]         kind;
    logic               notice;
  } entry_t;

  entry_t mem [SLOT_COUNT];
  entry_t rd_q;
  entry_t a_r, a_nxt;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  aabb_pkg::state_t state_r, state_nxt;
  logic [SLOT_COUNT-1:0] used_r, used_nxt, marked_r, marked_nxt;
  logic [IW-1:0] i_r, i_nxt, k_r, k_nxt;
  logic          found_r, found_nxt;

  // result produced this cycle
  logic          ov_nxt;
  logic [1:0]    oc_nxt;
  logic [2:0]    of_nxt, os_nxt;
  logic          on1_nxt, on2_nxt;

  logic [3:0] count;
  logic [IW-1:0] free_idx;
  logic          free_any;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    count = 4'd0;
    for (int j = 0; j < SLOT_COUNT; j++) count = count + 4'(used_r[j]);
    free_any = 1'b0;
    free_idx = '0;
    for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
      if (!used_r[j]) begin
        free_any = 1'b1;
        free_idx = IW'(j);
      end
    end
  end

  // overlap and notify for loaded slot i against read slot k
  logic signed [16:0] a_r_x, a_r_y, b_r_x, b_r_y;
  logic hit, n1, n2;
  always_comb begin
    a_r_x = 17'(a_r.left) + 17'($signed({1'b0, a_r.wid}));
    a_r_y = 17'(a_r.top) + 17'($signed({1'b0, a_r.hgt}));
    b_r_x = 17'(rd_q.left) + 17'($signed({1'b0, rd_q.wid}));
    b_r_y = 17'(rd_q.top) + 17'($signed({1'b0, rd_q.hgt}));
    hit = (a_r_x > 17'(rd_q.left)) && (17'(a_r.left) < b_r_x) &&
          (a_r_y > 17'(rd_q.top)) && (17'(a_r.top) < b_r_y);
    n1 = a_r.notice && aabb_pkg::permitted(a_r.kind, rd_q.kind);
    n2 = rd_q.notice && aabb_pkg::permitted(rd_q.kind, a_r.kind);
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    marked_nxt = marked_r;
    i_nxt = i_r;
    k_nxt = k_r;
    found_nxt = found_r;
    a_nxt = a_r;
    rd_addr = i_r;
    we = 1'b0;
    wr_addr = free_idx;
    wr_data = '{in_left_edge, in_top_edge, in_box_width, in_box_height,
                in_collider_kind, in_wants_notice};
    ov_nxt = 1'b0;
    oc_nxt = aabb_pkg::RES_DONE;
    of_nxt = 3'd0;
    os_nxt = 3'd0;
    on1_nxt = 1'b0;
    on2_nxt = 1'b0;
    unique case (state_r)
      aabb_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = aabb_pkg::ST_DONE;
          unique case (in_operation)
            aabb_pkg::OP_ADD: begin
              if (free_any) begin
                we = 1'b1;
                used_nxt[free_idx] = 1'b1;
                marked_nxt[free_idx] = 1'b0;
                oc_nxt = aabb_pkg::RES_ADD;
                of_nxt = 3'(free_idx);
              end else begin
                oc_nxt = aabb_pkg::RES_FULL;
              end
            end
            aabb_pkg::OP_MARK: begin
              if (32'(in_slot_index) < SLOT_COUNT &&
                  used_r[IW'(in_slot_index)])
                marked_nxt[IW'(in_slot_index)] = 1'b1;
            end
            aabb_pkg::OP_PURGE: begin
              used_nxt = used_r & ~marked_r;
              marked_nxt = '0;
            end
            aabb_pkg::OP_CLEAR: begin
              used_nxt = '0;
              marked_nxt = '0;
            end
            aabb_pkg::OP_CHECK: begin
              state_nxt = aabb_pkg::ST_LOAD;
              i_nxt = '0;
              found_nxt = 1'b0;
            end
            default: ;
          endcase
          ov_nxt = (state_nxt == aabb_pkg::ST_DONE);
        end
      end
      aabb_pkg::ST_LOAD: begin
        // read slot i; skip free rows
        rd_addr = i_r;
        if (32'(i_r) >= SLOT_COUNT - 1) begin
          state_nxt = aabb_pkg::ST_DONE;
          ov_nxt = !found_r;
        end else if (!used_r[i_r]) begin
          i_nxt = i_r + IW'(1);
        end else begin
          state_nxt = aabb_pkg::ST_READ;
          k_nxt = i_r + IW'(1);
        end
      end
      aabb_pkg::ST_READ: begin
        a_nxt = rd_q;
        rd_addr = k_r;
        state_nxt = aabb_pkg::ST_CMP;
      end
      aabb_pkg::ST_CMP: begin
        // rd_q holds slot k here
        if (used_r[k_r] && hit && (n1 || n2)) begin
          ov_nxt = 1'b1;
          oc_nxt = aabb_pkg::RES_PAIR;
          of_nxt = 3'(i_r);
          os_nxt = 3'(k_r);
          on1_nxt = n1;
          on2_nxt = n2;
          found_nxt = 1'b1;
        end
        if (32'(k_r) >= SLOT_COUNT - 1) begin
          i_nxt = i_r + IW'(1);
          state_nxt = aabb_pkg::ST_LOAD;
          // the final pair always ends the walk
          if (32'(i_r) >= SLOT_COUNT - 2) begin
            state_nxt = aabb_pkg::ST_DONE;
            if (!ov_nxt) ov_nxt = !found_r;
          end
        end else begin
          k_nxt = k_r + IW'(1);
          rd_addr = k_r + IW'(1);
        end
      end
      aabb_pkg::ST_DONE: state_nxt = aabb_pkg::ST_IDLE;
      default: state_nxt = aabb_pkg::ST_IDLE;
    endcase
  end

  // a pending pair may be the last only once the walk is known to end;
  // a held pair is flushed when the walk ends, with last set unless a new final pair comes with it
  logic          hp_r, hp_nxt;
  logic [2:0]    hf_r, hf_nxt, hs_r, hs_nxt;
  logic          h1_r, h1_nxt, h2_r, h2_nxt;
  logic          send;
  logic          walk_end;

  always_comb begin
    walk_end = (state_r != aabb_pkg::ST_IDLE) && (state_nxt == aabb_pkg::ST_DONE) &&
               (state_r != aabb_pkg::ST_DONE);
    hp_nxt = hp_r;
    hf_nxt = hf_r;
    hs_nxt = hs_r;
    h1_nxt = h1_r;
    h2_nxt = h2_r;
    send = 1'b0;
    if (state_r == aabb_pkg::ST_IDLE) hp_nxt = 1'b0;
    if (ov_nxt && oc_nxt == aabb_pkg::RES_PAIR) begin
      send = hp_r;
      hp_nxt = 1'b1;
      hf_nxt = of_nxt;
      hs_nxt = os_nxt;
      h1_nxt = on1_nxt;
      h2_nxt = on2_nxt;
    end
    if (walk_end) hp_nxt = 1'b0;
  end

  logic          ovr_r;
  logic [1:0]    ocr_r;
  logic [2:0]    ofr_r, osr_r;
  logic          o1r_r, o2r_r, olr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= aabb_pkg::ST_IDLE;
      used_r   <= '0;
      marked_r <= '0;
      ovr_r    <= 1'b0;
      hp_r     <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      marked_r <= marked_nxt;
      found_r  <= found_nxt;
      hp_r     <= hp_nxt;
      ovr_r    <= 1'b0;
      if (ov_nxt && oc_nxt != aabb_pkg::RES_PAIR) begin
        ovr_r <= 1'b1;
      end else if (send || (walk_end && (hp_r || ov_nxt))) begin
        ovr_r <= 1'b1;
      end
    end
    i_r  <= i_nxt;
    k_r  <= k_nxt;
    a_r  <= a_nxt;
    hf_r <= hf_nxt;
    hs_r <= hs_nxt;
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
    // payload of what goes out next cycle
    if (ov_nxt && oc_nxt != aabb_pkg::RES_PAIR) begin
      ocr_r <= oc_nxt; ofr_r <= of_nxt; osr_r <= 3'd0;
      o1r_r <= 1'b0; o2r_r <= 1'b0; olr_r <= 1'b1;
    end else if (send || (walk_end && hp_r)) begin
      ocr_r <= aabb_pkg::RES_PAIR; ofr_r <= hf_r; osr_r <= hs_r;
      o1r_r <= h1_r; o2r_r <= h2_r; olr_r <= walk_end && !ov_nxt;
    end else begin
      ocr_r <= aabb_pkg::RES_PAIR; ofr_r <= of_nxt; osr_r <= os_nxt;
      o1r_r <= on1_nxt; o2r_r <= on2_nxt; olr_r <= 1'b1;
    end
  end

  // a held pair and a new final pair in the same cycle: the held one goes
  // out first, the new one in the cycle after it as last
  logic          tail_set, tail_arm_r, tail_r;
  logic [2:0]    tf_r, ts_r;
  logic          t1_r, t2_r;
  assign tail_set = walk_end && hp_r && ov_nxt && (oc_nxt == aabb_pkg::RES_PAIR);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_arm_r <= 1'b0;
      tail_r     <= 1'b0;
    end else begin
      tail_arm_r <= tail_set;
      tail_r     <= tail_arm_r;
    end
    if (tail_set) begin
      tf_r <= of_nxt;
      ts_r <= os_nxt;
      t1_r <= on1_nxt;
      t2_r <= on2_nxt;
    end
  end

  assign busy = (state_r != aabb_pkg::ST_IDLE) || tail_arm_r || tail_r;
  assign out_valid = ovr_r || tail_r;
  assign out_result_code    = tail_r ? aabb_pkg::RES_PAIR : ocr_r;
  assign out_first_slot     = tail_r ? tf_r : ofr_r;
  assign out_second_slot    = tail_r ? ts_r : osr_r;
  assign out_notify_first   = tail_r ? t1_r : o1r_r;
  assign out_notify_second  = tail_r ? t2_r : o2r_r;
  assign out_last_result    = tail_r ? 1'b1 : olr_r;
  assign out_occupied_count = count;

endmodule

### bench/aabb_collider_table_pair_check_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb collider table pair check testbench
// directed table then random add/mark/purge/clear/check and unused-code items, every result
// compared in order against a behavioral model of the slot table
// ----------------------------------------------------------------------------
module aabb_collider_table_pair_check_core_tb;

  localparam int SLOTS = 8;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  idx;
    logic [15:0] left;
    logic [15:0] top;
    logic [14:0] wid;
    logic [14:0] hgt;
    logic [3:0]  kind;
    logic        notice;
  } item_t;

  typedef struct packed {
    logic [1:0] code;
    logic [2:0] first;
    logic [2:0] second;
    logic       nf;
    logic       ns;
    logic [3:0] count;
    logic       last;
  } hit_t;

  // directed row: item plus optional typed-in last result
  typedef struct packed {
    item_t it;
    logic  typed;
    hit_t  res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_operation = '0;
  logic [2:0] in_slot_index = '0;
  logic signed [15:0] in_left_edge = '0;
  logic signed [15:0] in_top_edge = '0;
  logic [14:0] in_box_width = '0;
  logic [14:0] in_box_height = '0;
  logic [3:0] in_collider_kind = '0;
  logic in_wants_notice = 1'b0;
  logic out_valid;
  logic [1:0] out_result_code;
  logic [2:0] out_first_slot;
  logic [2:0] out_second_slot;
  logic out_notify_first;
  logic out_notify_second;
  logic [3:0] out_occupied_count;
  logic out_last_result;

  aabb_collider_table_pair_check_core #(.SLOT_COUNT(SLOTS)) i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // model state
  logic        tab_used [SLOTS];
  logic        tab_mark [SLOTS];
  int          tab_left [SLOTS];
  int          tab_top [SLOTS];
  int          tab_wid [SLOTS];
  int          tab_hgt [SLOTS];
  logic [3:0]  tab_kind [SLOTS];
  logic        tab_notice [SLOTS];
  logic [8:0]  allow_rows [9] = '{9'h000, 9'h184, 9'h17A, 9'h004, 9'h104,
                                  9'h184, 9'h104, 9'h062, 9'h076};

  hit_t pending_hits[$];
  hit_t typed_hits[$];
  int   err_count = 0;
  int   free_run = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic may_hit(input logic [3:0] a, input logic [3:0] b);
    if (a > 4'd8 || b > 4'd8) return 1'b0;
    return allow_rows[a][b];
  endfunction

  function automatic logic [3:0] count_used();
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < SLOTS; i++) n += 4'(tab_used[i]);
    return n;
  endfunction

  task automatic predict_table(input item_t it);
    hit_t h;
    int n;
    logic n1, n2, ov;
    n = 0;
    h = '0;
    h.last = 1'b1;
    case (it.op)
      aabb_pkg::OP_ADD: begin
        h.code = aabb_pkg::RES_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!tab_used[i] && h.code == aabb_pkg::RES_FULL) begin
            tab_used[i] = 1'b1;
            tab_mark[i] = 1'b0;
            tab_left[i] = int'($signed(it.left));
            tab_top[i] = int'($signed(it.top));
            tab_wid[i] = int'(it.wid);
            tab_hgt[i] = int'(it.hgt);
            tab_kind[i] = it.kind;
            tab_notice[i] = it.notice;
            h.code = aabb_pkg::RES_ADD;
            h.first = 3'(i);
          end
        end
        h.count = count_used();
        pending_hits.push_back(h);
        return;
      end
      aabb_pkg::OP_MARK: if (tab_used[it.idx]) tab_mark[it.idx] = 1'b1;
      aabb_pkg::OP_PURGE: begin
        for (int i = 0; i < SLOTS; i++)
          if (tab_mark[i]) begin
            tab_used[i] = 1'b0;
            tab_mark[i] = 1'b0;
          end
      end
      aabb_pkg::OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          tab_used[i] = 1'b0;
          tab_mark[i] = 1'b0;
        end
      end
      aabb_pkg::OP_CHECK: begin
        for (int i = 0; i < SLOTS; i++)
          for (int k = i + 1; k < SLOTS; k++) begin
            ov = tab_used[i] && tab_used[k] &&
                 tab_left[i] + tab_wid[i] > tab_left[k] &&
                 tab_left[i] < tab_left[k] + tab_wid[k] &&
                 tab_top[i] + tab_hgt[i] > tab_top[k] &&
                 tab_top[i] < tab_top[k] + tab_hgt[k];
            n1 = tab_notice[i] && may_hit(tab_kind[i], tab_kind[k]);
            n2 = tab_notice[k] && may_hit(tab_kind[k], tab_kind[i]);
            if (ov && (n1 || n2)) begin
              h = '0;
              h.code = aabb_pkg::RES_PAIR;
              h.first = 3'(i);
              h.second = 3'(k);
              h.nf = n1;
              h.ns = n2;
              h.count = count_used();
              pending_hits.push_back(h);
              n++;
            end
          end
        if (n > 0) begin
          pending_hits[$].last = 1'b1;
          return;
        end
      end
      default: ;
    endcase
    h = '0;
    h.code = aabb_pkg::RES_DONE;
    h.last = 1'b1;
    h.count = count_used();
    pending_hits.push_back(h);
  endtask

  // result checker
  always @(posedge clk) begin
    hit_t want, want2;
    if (rst_n && out_valid) begin
      if (pending_hits.size() == 0) begin
        report("result with none expected");
      end else begin
        want = pending_hits.pop_front();
        if (out_result_code !== want.code)
          report($sformatf("code %0d want %0d", out_result_code, want.code));
        if (out_first_slot !== want.first)
          report($sformatf("first %0d want %0d", out_first_slot, want.first));
        if (out_second_slot !== want.second)
          report($sformatf("second %0d want %0d", out_second_slot, want.second));
        if (out_notify_first !== want.nf) report("notify_first");
        if (out_notify_second !== want.ns) report("notify_second");
        if (out_occupied_count !== want.count)
          report($sformatf("count %0d want %0d", out_occupied_count, want.count));
        if (out_last_result !== want.last) report("last_result");
        if (typed_hits.size() > 0 && pending_hits.size() == 0) begin
          want2 = typed_hits.pop_front();
          if (want2 !== want) report("typed expectation differs");
        end
      end
    end
  end

  // start is held while busy is high and drops between items
  task automatic send_item(input item_t it);
    @(posedge clk);
    while (free_run == 0 && $urandom_range(99) < 32) @(posedge clk);
    start <= 1'b1;
    in_operation <= it.op;
    in_slot_index <= it.idx;
    in_left_edge <= it.left;
    in_top_edge <= it.top;
    in_box_width <= it.wid;
    in_box_height <= it.hgt;
    in_collider_kind <= it.kind;
    in_wants_notice <= it.notice;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_table(it);
    start <= 1'b0;
  endtask

  function automatic item_t mk(input logic [2:0] op, input int l, input int t,
                               input int w, input int h, input int k,
                               input logic nt);
    item_t it;
    it = '0;
    it.op = op;
    it.left = 16'(l);
    it.top = 16'(t);
    it.wid = 15'(w);
    it.hgt = 15'(h);
    it.kind = 4'(k);
    it.notice = nt;
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int r;
    it = '0;
    r = $urandom_range(99);
    it.idx = 3'($urandom_range(7));
    // clustered boxes so checks find pairs; now and then full-range values
    if ($urandom_range(9) == 0) begin
      it.left = 16'($urandom);
      it.top = 16'($urandom);
      it.wid = 15'($urandom);
      it.hgt = 15'($urandom);
    end else begin
      it.left = 16'(int'($urandom_range(80)) - 40);
      it.top = 16'(int'($urandom_range(80)) - 40);
      it.wid = 15'($urandom_range(40));
      it.hgt = 15'($urandom_range(40));
    end
    it.kind = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
    it.notice = $urandom_range(3) != 0;
    if (r < 45) it.op = aabb_pkg::OP_ADD;
    else if (r < 62) it.op = aabb_pkg::OP_MARK;
    else if (r < 70) it.op = aabb_pkg::OP_PURGE;
    else if (r < 74) it.op = aabb_pkg::OP_CLEAR;
    else if (r < 97) it.op = aabb_pkg::OP_CHECK;
    else it.op = 3'($urandom_range(7, 5));
    return it;
  endfunction

  row_t rows[$];

  task automatic add_row(input item_t it, input logic typed, input hit_t res);
    row_t r;
    r.it = it;
    r.typed = typed;
    r.res = res;
    rows.push_back(r);
  endtask

  initial begin
    item_t it;
    int wait_cycles;
    for (int i = 0; i < SLOTS; i++) begin
      tab_used[i] = 1'b0;
      tab_mark[i] = 1'b0;
    end
    // after reset: empty check, then extremes, wall/player and overlap edges
    add_row(mk(aabb_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0), 1,
            '{aabb_pkg::RES_DONE, 0, 0, 0, 0, 0, 1});
    add_row(mk(aabb_pkg::OP_ADD, -32768, -32768, 32767, 32767, 1, 1), 1,
            '{aabb_pkg::RES_ADD, 0, 0, 0, 0, 1, 1});
    add_row(mk(aabb_pkg::OP_ADD, 32767, 32767, 32767, 32767, 2, 1), 1,
            '{aabb_pkg::RES_ADD, 1, 0, 0, 0, 2, 1});
    add_row(mk(aabb_pkg::OP_ADD, 0, 0, 10, 10, 2, 1), 0, '0);
    add_row(mk(aabb_pkg::OP_ADD, 10, 0, 10, 10, 3, 1), 0, '0);   // touching only
    add_row(mk(aabb_pkg::OP_ADD, 5, 5, 0, 10, 3, 1), 0, '0);     // zero width
    add_row(mk(aabb_pkg::OP_ADD, 5, 5, 3, 3, 15, 1), 0, '0);     // kind above range
    add_row(mk(aabb_pkg::OP_ADD, 4, 4, 3, 3, 3, 0), 0, '0);
    add_row(mk(aabb_pkg::OP_ADD, 1, 1, 2, 2, 7, 1), 1,
            '{aabb_pkg::RES_ADD, 7, 0, 0, 0, 8, 1});
    add_row(mk(aabb_pkg::OP_ADD, 0, 0, 1, 1, 6, 1), 1,
            '{aabb_pkg::RES_FULL, 0, 0, 0, 0, 8, 1});
    add_row(mk(aabb_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0), 0, '0);
    it = mk(aabb_pkg::OP_MARK, 0, 0, 0, 0, 0, 0); it.idx = 3'd7;
    add_row(it, 1, '{aabb_pkg::RES_DONE, 0, 0, 0, 0, 8, 1});
    it.idx = 3'd0;
    add_row(it, 0, '0);
    add_row(mk(aabb_pkg::OP_PURGE, 0, 0, 0, 0, 0, 0), 1,
            '{aabb_pkg::RES_DONE, 0, 0, 0, 0, 6, 1});
    add_row(it, 0, '0);                                 // mark of free slot
    add_row(mk(aabb_pkg::OP_PURGE, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(3'd5, 0, 0, 0, 0, 0, 0), 1, '{aabb_pkg::RES_DONE, 0, 0, 0, 0, 6, 1});
    add_row(mk(3'd7, 0, 0, 0, 0, 0, 0), 1, '{aabb_pkg::RES_DONE, 0, 0, 0, 0, 6, 1});
    add_row(mk(aabb_pkg::OP_ADD, 3, 3, 4, 4, 8, 1), 0, '0);
    add_row(mk(aabb_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(aabb_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0), 1,
            '{aabb_pkg::RES_DONE, 0, 0, 0, 0, 0, 1});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[j]) begin
      if (rows[j].typed) typed_hits.push_back(rows[j].res);
      send_item(rows[j].it);
      while (pending_hits.size() > 0) @(posedge clk);
    end
    for (int n = 0; n < 230; n++) begin
      free_run = (n >= 100 && n < 150);
      send_item(rand_item());
    end
    wait_cycles = 0;
    while (pending_hits.size() > 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (err_count == 0 && pending_hits.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
sv/aabb_pkg.sv
sv/aabb_collider_table_pair_check_core.sv
bench/aabb_collider_table_pair_check_core_tb.sv
